>>> design/masked_hw_address_acl_match_defines.svh
// Assertion macros shared by the access list RTL.
// No dependencies; included by masked_hw_address_acl_match, which checks its own logic.
`ifndef MASKED_HW_ADDRESS_ACL_MATCH_DEFINES_SVH
`define MASKED_HW_ADDRESS_ACL_MATCH_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define HWACL_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("hwacl assertion failed");

`define HWACL_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("hwacl assertion failed");

`else

`define HWACL_ASSERT(label, prop)

`define HWACL_ASSERT_NEXT(label, pre, post)

`endif

`endif

>>> design/hwacl_pkg.sv
// Constants for the hardware address access list: field layout and codes.
// No dependencies.
package hwacl_pkg;

  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;
  localparam int CfgW     = 12;

  localparam int IdxW     = 11;
  localparam int TypeW    = 8;
  localparam int WordW    = 64;
  localparam int LenW     = 5;

  localparam int InIdxLsb   = 0;
  localparam int InTypeLsb  = InIdxLsb + IdxW;
  localparam int InAddrHiLsb = InTypeLsb + TypeW;
  localparam int InAddrLoLsb = InAddrHiLsb + WordW;
  localparam int InMaskHiLsb = InAddrLoLsb + WordW;
  localparam int InMaskLoLsb = InMaskHiLsb + WordW;
  localparam int InAllowLsb  = InMaskLoLsb + WordW;
  localparam int InLenLsb    = InAllowLsb + 1;
  localparam int InDataW     = 288;

  localparam int OutDataW    = 16;

  localparam logic ActLookup = 1'b0;
  localparam logic ActWrite  = 1'b1;

  localparam logic RegActiveEntries = 1'b0;

endpackage

>>> design/hwacl_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module hwacl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/masked_hw_address_acl_match.sv
// Channel     | Dir | Signals                 | Carries
// s_axis      | in  | tvalid tready tdata tuser | lookup key or table entry write
// m_axis      | out | tvalid tready tdata     | decision, hit flag, matching index
// apb         | in  | psel penable pwrite ... | active_entries register
//
// A write transfer stores the entry as it is accepted; its result goes through S_DONE to the output register.
// A lookup reads one entry per cycle from the entry RAM, comparing up to
// min(active_entries, TABLE_DEPTH) entries, and stops sooner on a match.
// One item is processed at a time; the next is taken while the result waits in the
// output register. The entry RAM is not cleared after reset; entries are valid once written.
// Depends on hwacl_pkg, hwacl_ram and the assertion macro header.
`include "masked_hw_address_acl_match_defines.svh"

module masked_hw_address_acl_match
  import hwacl_pkg::*;
#(
  parameter int TABLE_DEPTH = 2048,
  parameter int ADDR_BYTES  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // index, hw_type, addr_hi, addr_lo, mask_hi, mask_lo, allow_bit, key_len, zero fill
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // action
  input  logic                s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // allowed, hit, match_index, zero fill
  output logic [OutDataW-1:0] m_axis_tdata_o,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [ApbAddrW-1:0] paddr_i,
  input  logic [ApbDataW-1:0] pwdata_i,
  output logic [ApbDataW-1:0] prdata_o,
  output logic                pready_o
);

  localparam int AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int KeyW  = 8 * ADDR_BYTES;
  localparam int EntW  = 1 + TypeW + 2 * KeyW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e              state_q, state_d;
  logic [CfgW-1:0]     active_q, active_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cmp_idx_q, cmp_idx_d;
  logic                cmp_vld_q, cmp_vld_d;
  logic [TypeW-1:0]    key_type_q, key_type_d;
  logic [KeyW-1:0]     key_addr_q, key_addr_d;
  logic [ADDR_BYTES-1:0] key_en_q, key_en_d;
  logic                res_allow_q, res_allow_d;
  logic                res_hit_q, res_hit_d;
  logic [IdxW-1:0]     res_idx_q, res_idx_d;
  logic                out_vld_q, out_vld_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic                in_acc;
  logic                out_free;
  logic                cfg_wr;
  logic [IdxW-1:0]     in_index;
  logic [TypeW-1:0]    in_type;
  logic [2*WordW-1:0]  in_addr;
  logic [2*WordW-1:0]  in_mask;
  logic                in_allow;
  logic [LenW-1:0]     in_len;
  logic [LenW-1:0]     len_sat;
  logic                ram_we;
  logic [EntW-1:0]     ram_wdata;
  logic                ram_re;
  logic [EntW-1:0]     ram_rdata;
  logic                ent_allow;
  logic [TypeW-1:0]    ent_type;
  logic [KeyW-1:0]     ent_addr;
  logic [KeyW-1:0]     ent_mask;
  logic [ADDR_BYTES-1:0] byte_ok;
  logic                ent_match;
  logic                cmp_last;

  assign in_index = s_axis_tdata_i[InIdxLsb +: IdxW];
  assign in_type  = s_axis_tdata_i[InTypeLsb +: TypeW];
  assign in_addr  = {s_axis_tdata_i[InAddrHiLsb +: WordW], s_axis_tdata_i[InAddrLoLsb +: WordW]};
  assign in_mask  = {s_axis_tdata_i[InMaskHiLsb +: WordW], s_axis_tdata_i[InMaskLoLsb +: WordW]};
  assign in_allow = s_axis_tdata_i[InAllowLsb];
  assign in_len   = s_axis_tdata_i[InLenLsb +: LenW];
  assign len_sat  = (in_len > LenW'(ADDR_BYTES)) ? LenW'(ADDR_BYTES) : in_len;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_vld_q || m_axis_tready_i;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && pready_o
                    && (paddr_i[2] == RegActiveEntries);
  assign prdata_o = (paddr_i[2] == RegActiveEntries) ? ApbDataW'(active_q) : '0;

  assign ram_we    = in_acc && (s_axis_tuser_i == ActWrite)
                     && (32'(in_index) < 32'(TABLE_DEPTH));
  assign ram_wdata = {in_allow, in_type, in_addr[2*WordW-1 -: KeyW], in_mask[2*WordW-1 -: KeyW]};
  assign ram_re    = (state_q == S_SCAN) && (rd_ptr_q < count_q);

  hwacl_ram #(
    .Width (EntW),
    .Depth (TABLE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AddrW'(in_index)),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign ent_allow = ram_rdata[EntW-1];
  assign ent_type  = ram_rdata[EntW-2 -: TypeW];
  assign ent_addr  = ram_rdata[KeyW +: KeyW];
  assign ent_mask  = ram_rdata[0 +: KeyW];

  always_comb begin
    for (int b = 0; b < ADDR_BYTES; b++) begin
      byte_ok[b] = !key_en_q[b]
                   || ((key_addr_q[b*8 +: 8] & ent_mask[b*8 +: 8]) == ent_addr[b*8 +: 8]);
    end
  end

  assign ent_match = (ent_type == key_type_q) && (&byte_ok);
  assign cmp_last  = (CntW'(cmp_idx_q + 1'b1) == count_q);

  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    count_d     = count_q;
    rd_ptr_d    = rd_ptr_q;
    cmp_idx_d   = cmp_idx_q;
    cmp_vld_d   = 1'b0;
    key_type_d  = key_type_q;
    key_addr_d  = key_addr_q;
    key_en_d    = key_en_q;
    res_allow_d = res_allow_q;
    res_hit_d   = res_hit_q;
    res_idx_d   = res_idx_q;
    out_vld_d   = out_vld_q;
    out_data_d  = out_data_q;

    if (cfg_wr) begin
      active_d = pwdata_i[CfgW-1:0];
    end

    if (out_vld_q && m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_allow_d = 1'b0;
          res_hit_d   = 1'b0;
          res_idx_d   = '0;
          rd_ptr_d    = '0;
          key_type_d  = in_type;
          key_addr_d  = in_addr[2*WordW-1 -: KeyW];
          for (int b = 0; b < ADDR_BYTES; b++) begin
            key_en_d[b] = (LenW'(ADDR_BYTES - 1 - b) < len_sat);
          end
          if (32'(active_q) > 32'(TABLE_DEPTH)) begin
            count_d = CntW'(TABLE_DEPTH);
          end else begin
            count_d = CntW'(active_q);
          end
          if (s_axis_tuser_i == ActWrite) begin
            state_d = S_DONE;
          end else if (active_q == '0) begin
            res_allow_d = 1'b1;
            state_d     = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (ram_re) begin
          rd_ptr_d  = rd_ptr_q + 1'b1;
          cmp_idx_d = rd_ptr_q;
          cmp_vld_d = 1'b1;
        end
        if (cmp_vld_q) begin
          if (ent_match) begin
            res_allow_d = ent_allow;
            res_hit_d   = 1'b1;
            res_idx_d   = IdxW'(cmp_idx_q);
            cmp_vld_d   = 1'b0;
            state_d     = S_DONE;
          end else if (cmp_last) begin
            res_allow_d = 1'b1;
            cmp_vld_d   = 1'b0;
            state_d     = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_data_d = OutDataW'({res_idx_q, res_hit_q, res_allow_q});
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      active_q  <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      active_q  <= active_d;
      cmp_vld_q <= cmp_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q     <= count_d;
    rd_ptr_q    <= rd_ptr_d;
    cmp_idx_q   <= cmp_idx_d;
    key_type_q  <= key_type_d;
    key_addr_q  <= key_addr_d;
    key_en_q    <= key_en_d;
    res_allow_q <= res_allow_d;
    res_hit_q   <= res_hit_d;
    res_idx_q   <= res_idx_d;
    out_data_q  <= out_data_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

  `HWACL_ASSERT(a_cmp_only_in_scan, cmp_vld_q |-> (state_q == S_SCAN))
  `HWACL_ASSERT_NEXT(a_write_goes_done, in_acc && (s_axis_tuser_i == ActWrite), state_q == S_DONE)
  `HWACL_ASSERT(a_ready_no_compare, s_axis_tready_o |-> !cmp_vld_q)
  `HWACL_ASSERT_NEXT(a_done_loads_output, (state_q == S_DONE) && out_free, out_vld_q)

endmodule
